/* rtl/core/alts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alts_pkg: shared types for the aging LRU tag store
// Opcodes, register indexes, the entry word and the scan control group.
// ----------------------------------------------------------------------------
package alts_pkg;

  localparam int KEY_W   = 32;
  localparam int AGE_W   = 8;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 4;
  localparam int ACT_W   = 5;
  localparam int CFG_W   = 8;

  localparam logic [AGE_W-1:0] AGE_SAT = '1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_TICK   = 2'd1,
    OP_INVAL  = 2'd2,
    OP_RSVD   = 2'd3   // unused: no state change, no result
  } alts_op_e;

  typedef enum logic {
    CFG_ACTIVE  = 1'b0,
    CFG_MAX_AGE = 1'b1
  } alts_cfg_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [AGE_W-1:0]   age;
    logic [STAMP_W-1:0] stamp;
  } alts_entry_t;

  typedef struct packed {
    logic clear;    // restart the trackers for a new request
    logic cmp_vld;  // read data of one entry is present this cycle
    logic tick;     // aging pass instead of a lookup
  } alts_scan_ctrl_t;

endpackage

/* rtl/core/aging_lru_tag_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_lru_tag_store: fully associative tag store, LRU victim, age expiry
// Sequencer, valid marks and result register around one compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the opcode (lookup,
//   tick, invalidate all), tdata the 32-bit key. A lookup returns one result
//   on m_axis (hit flag, slot index); tick and invalidate return nothing.
//   Lookup and tick walk the active entries through the entry RAM, one entry
//   per cycle. A request runs through the accept cycle, one read per active
//   entry, the last compare after the registered RAM read, a step to leave
//   the scan, and for a lookup the decision and write-back. The single RAM
//   read port sets this pace. Invalidate all and the unused opcode complete
//   in the cycle in which they are accepted.
//   s_axis_tready is high only while the sequencer is idle. A finished result
//   waits in the output register; the next request is accepted meanwhile and
//   only its own write-back waits if the receiver still stalls.
//   Reset clears all valid marks and the stamp counter and loads
//   active_entries = 16, max_age = 255. Configuration writes go through
//   cfg_we_i / cfg_idx_i / cfg_data_i, by the user only while idle (the block
//   does not enforce it); writing active_entries flushes the store. Entry
//   RAM needs no clearing pass: an entry is only used once its valid mark is set.
// ----------------------------------------------------------------------------
module aging_lru_tag_store
  import alts_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request channel
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // [31:0] key
  input  logic [1:0]       s_axis_tuser,   // [1:0] opcode
  // result channel
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] hit, [4:1] slot_index, [7:5] zero
  // configuration
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CLAMP_W = (CNT_W > ACT_W) ? CNT_W : ACT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                 tick_q, tick_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [ENTRIES-1:0]   valid_q, valid_d;
  logic [STAMP_W-1:0]   next_stamp_q, next_stamp_d;
  logic [ACT_W-1:0]     active_q, active_d;
  logic [AGE_W-1:0]     max_age_q, max_age_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_hit_q, out_hit_d;
  logic [SLOT_W-1:0]    out_slot_q, out_slot_d;

  logic [CLAMP_W-1:0]   act_ext;
  logic [CNT_W-1:0]     n_eff;
  logic                 issue;
  logic                 accept;
  logic                 can_load;
  alts_op_e             op;

  alts_scan_ctrl_t      scan_ctrl;
  logic                 tick_we;
  alts_entry_t          tick_word;
  logic                 expire;
  logic                 scan_hit;
  logic [IDX_W-1:0]     scan_slot;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  alts_entry_t          ram_wdata;
  alts_entry_t          ram_rdata;

  // Clamp the active count to 1..ENTRIES.
  always_comb begin
    act_ext = CLAMP_W'(active_q);
    if (act_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (act_ext > CLAMP_W'(ENTRIES)) begin
      n_eff = CNT_W'(ENTRIES);
    end else begin
      n_eff = CNT_W'(act_ext);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = alts_op_e'(s_axis_tuser);
  assign issue         = (state_q == ST_SCAN) && (rd_cnt_q < n_eff);
  assign can_load      = !out_vld_q || m_axis_tready;

  assign scan_ctrl.clear   = accept;
  assign scan_ctrl.cmp_vld = cmp_vld_q;
  assign scan_ctrl.tick    = tick_q;

  alts_scan_unit #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .idx_i       (cmp_idx_q),
    .entry_vld_i (valid_q[cmp_idx_q]),
    .entry_i     (ram_rdata),
    .key_i       (key_q),
    .max_age_i   (max_age_q),
    .wr_en_o     (tick_we),
    .wr_word_o   (tick_word),
    .expire_o    (expire),
    .hit_o       (scan_hit),
    .slot_o      (scan_slot)
  );

  // Write port: aged entry during a tick pass, installed entry on write-back.
  always_comb begin
    if (state_q == ST_WRITE) begin
      ram_we          = can_load;
      ram_waddr       = scan_slot;
      ram_wdata.key   = key_q;
      ram_wdata.age   = '0;
      ram_wdata.stamp = next_stamp_q;
    end else begin
      ram_we    = tick_we;
      ram_waddr = cmp_idx_q;
      ram_wdata = tick_word;
    end
  end

  alts_entry_ram #(
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    rd_cnt_d     = rd_cnt_q;
    cmp_vld_d    = issue;
    cmp_idx_d    = rd_cnt_q[IDX_W-1:0];
    tick_d       = tick_q;
    key_d        = key_q;
    valid_d      = valid_q;
    next_stamp_d = next_stamp_q;
    active_d     = active_q;
    max_age_d    = max_age_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_hit_d    = out_hit_q;
    out_slot_d   = out_slot_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d    = s_axis_tdata;
          rd_cnt_d = '0;
          case (op)
            OP_LOOKUP: begin
              tick_d  = 1'b0;
              state_d = ST_SCAN;
            end
            OP_TICK: begin
              tick_d  = 1'b1;
              state_d = ST_SCAN;
            end
            OP_INVAL: begin
              valid_d = '0;
            end
            default: begin
              // unused opcode: drop
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_cnt_d = rd_cnt_q + CNT_W'(1);
        end
        if (expire) begin
          valid_d[cmp_idx_q] = 1'b0;
        end
        if (!issue && !cmp_vld_q) begin
          state_d = tick_q ? ST_IDLE : ST_WRITE;
        end
      end
      ST_WRITE: begin
        // hold the write-back until the result register is free
        if (can_load) begin
          valid_d[scan_slot] = 1'b1;
          next_stamp_d       = next_stamp_q + STAMP_W'(1);
          out_vld_d          = 1'b1;
          out_hit_d          = scan_hit;
          out_slot_d         = SLOT_W'(scan_slot);
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (alts_cfg_e'(cfg_idx_i))
        CFG_ACTIVE: begin
          active_d     = cfg_data_i[ACT_W-1:0];
          valid_d      = '0;
          next_stamp_d = '0;
        end
        CFG_MAX_AGE: begin
          max_age_d = cfg_data_i[AGE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_cnt_q     <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      tick_q       <= 1'b0;
      key_q        <= '0;
      valid_q      <= '0;
      next_stamp_q <= '0;
      active_q     <= ACT_W'(16);
      max_age_q    <= AGE_SAT;
      out_vld_q    <= 1'b0;
      out_hit_q    <= 1'b0;
      out_slot_q   <= '0;
    end else begin
      state_q      <= state_d;
      rd_cnt_q     <= rd_cnt_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_idx_q    <= cmp_idx_d;
      tick_q       <= tick_d;
      key_q        <= key_d;
      valid_q      <= valid_d;
      next_stamp_q <= next_stamp_d;
      active_q     <= active_d;
      max_age_q    <= max_age_d;
      out_vld_q    <= out_vld_d;
      out_hit_q    <= out_hit_d;
      out_slot_q   <= out_slot_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_slot_q, out_hit_q};

  // No compare data may linger once the sequencer is back at idle.
  a_idle_no_cmp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !cmp_vld_q)
    else $error("compare data present while idle");

  // The scan never reads past the active entries.
  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_cnt_q <= n_eff))
    else $error("scan ran past the active entries");

  // Each installed or refreshed entry takes exactly one new stamp.
  a_stamp_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && can_load && !cfg_we_i) |=>
      (next_stamp_q == $past(next_stamp_q) + STAMP_W'(1)))
    else $error("stamp counter did not advance by one");

  // After write-back the store holds at least one valid entry and a result.
  a_write_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && can_load && !cfg_we_i) |=>
      (valid_q != '0) && out_vld_q)
    else $error("write-back left no valid entry or no result");

endmodule

/* rtl/core/alts_entry_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alts_entry_ram: entry storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module alts_entry_ram
  import alts_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  alts_entry_t   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output alts_entry_t   rdata_o
);

  alts_entry_t mem [DEPTH];
  alts_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/alts_scan_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alts_scan_unit: per-entry compare unit
// Sees one entry per cycle; tracks first hit and LRU victim, or ages entries.
// ----------------------------------------------------------------------------
module alts_scan_unit
  import alts_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  alts_scan_ctrl_t  ctrl_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic             entry_vld_i,
  input  alts_entry_t      entry_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [AGE_W-1:0] max_age_i,
  output logic             wr_en_o,
  output alts_entry_t      wr_word_o,
  output logic             expire_o,
  output logic             hit_o,
  output logic [IDX_W-1:0] slot_o
);

  logic               hit_q, hit_d;
  logic               inv_q, inv_d;
  logic               have_q, have_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]   vic_idx_q, vic_idx_d;
  logic [AGE_W-1:0]   best_age_q, best_age_d;
  logic [STAMP_W-1:0] best_stamp_q, best_stamp_d;
  logic [AGE_W-1:0]   age_inc;
  logic               older;

  // Aging: saturate, expire at or above the limit.
  always_comb begin
    age_inc = (entry_i.age == AGE_SAT) ? AGE_SAT : entry_i.age + AGE_W'(1);
    wr_word_o       = entry_i;
    wr_word_o.age   = age_inc;
    wr_en_o         = ctrl_i.cmp_vld && ctrl_i.tick && entry_vld_i;
    expire_o        = wr_en_o && (age_inc >= max_age_i);
  end

  always_comb begin
    older = !have_q || (entry_i.age > best_age_q) ||
            ((entry_i.age == best_age_q) && (entry_i.stamp < best_stamp_q));
    hit_d        = hit_q;
    inv_d        = inv_q;
    have_d       = have_q;
    hit_idx_d    = hit_idx_q;
    vic_idx_d    = vic_idx_q;
    best_age_d   = best_age_q;
    best_stamp_d = best_stamp_q;
    if (ctrl_i.clear) begin
      hit_d  = 1'b0;
      inv_d  = 1'b0;
      have_d = 1'b0;
    end else if (ctrl_i.cmp_vld && !ctrl_i.tick) begin
      if (entry_vld_i && (entry_i.key == key_i) && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = idx_i;
      end
      if (!inv_q) begin
        if (!entry_vld_i) begin
          inv_d     = 1'b1;
          vic_idx_d = idx_i;
        end else if (older) begin
          have_d       = 1'b1;
          vic_idx_d    = idx_i;
          best_age_d   = entry_i.age;
          best_stamp_d = entry_i.stamp;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      inv_q  <= 1'b0;
      have_q <= 1'b0;
    end else begin
      hit_q  <= hit_d;
      inv_q  <= inv_d;
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q    <= hit_idx_d;
    vic_idx_q    <= vic_idx_d;
    best_age_q   <= best_age_d;
    best_stamp_q <= best_stamp_d;
  end

  assign hit_o  = hit_q;
  assign slot_o = hit_q ? hit_idx_q : vic_idx_q;

endmodule

/* test/alts_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alts_stream_checker: predictor and scoreboard for the aging LRU tag store
// Watches the request, result and configuration ports, keeps its own copy
// of the entry table and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module alts_stream_checker
  import alts_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_ready_i,
  input  logic [31:0]      req_key_i,
  input  logic [1:0]       req_op_i,
  input  logic             rsp_valid_i,
  input  logic             rsp_ready_i,
  input  logic [7:0]       rsp_data_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               err_cnt_o,
  output int               pending_o
);

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } lookup_answer_t;

  logic               tag_valid [ENTRIES];
  logic [KEY_W-1:0]   tag_key   [ENTRIES];
  logic [AGE_W-1:0]   tag_age   [ENTRIES];
  logic [STAMP_W-1:0] tag_stamp [ENTRIES];
  logic [STAMP_W-1:0] stamp_ctr;
  logic [ACT_W-1:0]   active_reg;
  logic [AGE_W-1:0]   max_age_reg;

  lookup_answer_t lookup_answers_q[$];
  lookup_answer_t want;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, exp_val);
    err_cnt_o++;
  endtask

  task automatic flush_table();
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      tag_valid[i] = 1'b0;
      tag_key[i]   = '0;
      tag_age[i]   = '0;
      tag_stamp[i] = '0;
    end
    stamp_ctr = '0;
  endtask

  // Active count is clamped to 1..ENTRIES.
  function automatic int entries_in_use();
    if (active_reg == 0) return 1;
    if (active_reg > ENTRIES) return ENTRIES;
    return int'(active_reg);
  endfunction

  task automatic apply_tag_op(input logic [1:0] op, input logic [KEY_W-1:0] key);
    int             n;
    int             i;
    int             slot;
    logic           found;
    logic           done;
    logic           have;
    logic [AGE_W-1:0]   best_age;
    logic [STAMP_W-1:0] best_stamp;
    lookup_answer_t ans;
    n = entries_in_use();
    case (op)
      OP_TICK: begin
        for (i = 0; i < n; i++) begin
          if (tag_valid[i]) begin
            if (tag_age[i] != AGE_SAT) tag_age[i] = tag_age[i] + 1'b1;
            if (tag_age[i] >= max_age_reg) tag_valid[i] = 1'b0;
          end
        end
      end
      OP_INVAL: begin
        for (i = 0; i < ENTRIES; i++) tag_valid[i] = 1'b0;
      end
      OP_LOOKUP: begin
        found = 1'b0;
        slot  = 0;
        for (i = 0; i < n; i++) begin
          if (!found && tag_valid[i] && tag_key[i] == key) begin
            found = 1'b1;
            slot  = i;
          end
        end
        if (!found) begin
          // First free entry, else oldest age, then lowest stamp, then index.
          done       = 1'b0;
          have       = 1'b0;
          best_age   = '0;
          best_stamp = '0;
          for (i = 0; i < n; i++) begin
            if (!done) begin
              if (!tag_valid[i]) begin
                slot = i;
                done = 1'b1;
              end else if (!have || tag_age[i] > best_age ||
                           (tag_age[i] == best_age && tag_stamp[i] < best_stamp)) begin
                slot       = i;
                best_age   = tag_age[i];
                best_stamp = tag_stamp[i];
                have       = 1'b1;
              end
            end
          end
        end
        tag_valid[slot] = 1'b1;
        tag_key[slot]   = key;
        tag_age[slot]   = '0;
        tag_stamp[slot] = stamp_ctr;
        stamp_ctr       = stamp_ctr + 1'b1;
        ans.hit  = found;
        ans.slot = slot[SLOT_W-1:0];
        lookup_answers_q.push_back(ans);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_reg  = 5'd16;
      max_age_reg = 8'd255;
      flush_table();
      lookup_answers_q.delete();
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      // Results first: a result at this edge never belongs to a request
      // accepted at the same edge.
      if (rsp_valid_i && rsp_ready_i) begin
        if (lookup_answers_q.size() == 0) begin
          report_mismatch("unexpected result", int'(rsp_data_i), -1);
        end else begin
          want = lookup_answers_q.pop_front();
          if (rsp_data_i[0] !== want.hit)
            report_mismatch("hit", int'(rsp_data_i[0]), int'(want.hit));
          if (rsp_data_i[4:1] !== want.slot)
            report_mismatch("slot_index", int'(rsp_data_i[4:1]), int'(want.slot));
          if (rsp_data_i[7:5] !== 3'b000)
            report_mismatch("tdata padding", int'(rsp_data_i[7:5]), 0);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ACTIVE) begin
          active_reg = cfg_data_i[ACT_W-1:0];
          flush_table();
        end else begin
          max_age_reg = cfg_data_i[AGE_W-1:0];
        end
      end
      if (req_valid_i && req_ready_i) apply_tag_op(req_op_i, req_key_i);
      pending_o = lookup_answers_q.size();
    end
  end

endmodule

/* test/aging_lru_tag_store_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_lru_tag_store_tb: stimulus and verdict for the aging LRU tag store
// Directed lookups, ticks and flushes, then random segments under several
// register settings and handshake idling patterns; a checker alongside the
// block predicts and compares every lookup result.
// ----------------------------------------------------------------------------
module aging_lru_tag_store_tb;
  import alts_pkg::*;

  localparam int ENTRIES       = 16;
  localparam int SETTLE_CYCLES = 24;      // covers one tick scan at full depth
  localparam int SEG_ITEMS     = 85;      // counted requests per random segment
  localparam int CYCLE_LIMIT   = 400000;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata  = '0;   // [31:0] key
  logic [1:0]       s_axis_tuser  = '0;   // [1:0] opcode
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;         // [0] hit, [4:1] slot_index, [7:5] zero
  logic             cfg_we_i      = 1'b0;
  logic             cfg_idx_i     = 1'b0;
  logic [CFG_W-1:0] cfg_data_i    = '0;

  int err_cnt;
  int pending;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Register settings per random segment. Active count data carries stray
  // upper bits in some segments (0xE0 -> 0 -> one entry, 0x1F -> clamp to
  // full depth, 0xA3 -> 3, 0x50 -> 16); segment 6 is randomized.
  logic [7:0] seg_active [8] = '{8'h10, 8'h01, 8'hE0, 8'h1F, 8'h04, 8'hA3, 8'h00, 8'h50};
  logic [7:0] seg_max_age[8] = '{8'hFF, 8'h00, 8'h03, 8'h01, 8'h06, 8'hFF, 8'h00, 8'h0C};

  logic [31:0] key_pool[16];

  aging_lru_tag_store #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  alts_stream_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_i(s_axis_tready),
    .req_key_i  (s_axis_tdata),
    .req_op_i   (s_axis_tuser),
    .rsp_valid_i(m_axis_tvalid),
    .rsp_ready_i(m_axis_tready),
    .rsp_data_i (m_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: end the run if the block hangs or results go missing.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("aging_lru_tag_store_tb NOT OK");
      $finish;
    end
  end

  // Receiver: stall at random with the current percentage; update on the
  // falling edge so the block samples a settled value.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one request at the falling edge, optionally after idle cycles,
  // and hold it until the block accepts it. Returns at a falling edge with
  // tvalid still high, so back-to-back requests keep tvalid up.
  task automatic send_request(input logic [1:0] op, input logic [31:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= key;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop the request channel, wait for every outstanding result, then give
  // a trailing tick time to finish its scan.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register write, one cycle wide; returns after the pulse has ended.
  task automatic write_reg(input alts_cfg_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int          seg;
    int          sent;
    int          pool_n;
    int          k;
    int          r;
    logic [1:0]  op;
    logic [31:0] key;

    // Reset: hold it low, then release it away from the rising edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- Directed part, reset settings (16 entries, max age 255) ----
    send_request(OP_LOOKUP, 32'h0000_0000);   // miss into slot 0
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);   // miss into slot 1
    send_request(OP_LOOKUP, 32'h0000_0000);   // hit slot 0
    send_request(OP_RSVD,   32'h5A5A_A5A5);   // unused opcode: no effect
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);   // hit slot 1
    send_request(OP_TICK,   32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'h0000_0000);   // hit, age cleared
    send_request(OP_INVAL,  32'h1234_5678);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);   // miss after flush, slot 0
    settle();

    // Two entries, expire after two ticks: exercise stamp and age victims.
    write_reg(CFG_ACTIVE,  8'd2);
    write_reg(CFG_MAX_AGE, 8'd2);
    send_request(OP_LOOKUP, 32'hA000_0001);
    send_request(OP_LOOKUP, 32'hB000_0002);
    send_request(OP_LOOKUP, 32'hA000_0001);   // hit, restamp
    send_request(OP_LOOKUP, 32'hC000_0003);   // full: equal ages, oldest stamp
    send_request(OP_TICK,   32'h0);
    send_request(OP_LOOKUP, 32'hA000_0001);   // hit clears its age
    send_request(OP_LOOKUP, 32'hD000_0004);   // full: highest age wins
    send_request(OP_TICK,   32'h0);
    send_request(OP_TICK,   32'h0);           // everything expires
    send_request(OP_LOOKUP, 32'hA000_0001);
    settle();

    // Max age zero: the next tick drops every valid entry.
    write_reg(CFG_MAX_AGE, 8'd0);
    send_request(OP_LOOKUP, 32'h7777_8888);
    send_request(OP_TICK,   32'h0);
    send_request(OP_LOOKUP, 32'h7777_8888);   // miss again
    settle();

    // ---- Random segments ----
    for (seg = 0; seg < 8; seg++) begin
      if (seg == 6) begin
        seg_active[6]  = 8'($urandom_range(16, 1)) | (8'($urandom_range(7)) << 5);
        seg_max_age[6] = 8'($urandom_range(10, 2));
      end
      write_reg(CFG_ACTIVE,  seg_active[seg]);
      write_reg(CFG_MAX_AGE, seg_max_age[seg]);

      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase

      // Key pool of the active count, capped at six, plus one to three keys, so
      // the store hits often and small stores still have to pick victims.
      pool_n = seg_active[seg][4:0];
      if (pool_n < 1) pool_n = 1;
      if (pool_n > 6) pool_n = 6;
      pool_n = pool_n + $urandom_range(3, 1);
      for (k = 0; k < 16; k++) begin
        if ($urandom_range(9) == 0) key_pool[k] = k[0] ? 32'hFFFF_FFFF : 32'h0;
        else key_pool[k] = $urandom;
      end

      sent = 0;
      while (sent < SEG_ITEMS) begin
        r = $urandom_range(99);
        if (r < 70)      op = OP_LOOKUP;
        else if (r < 88) op = OP_TICK;
        else if (r < 94) op = OP_INVAL;
        else             op = OP_RSVD;
        if (op == OP_LOOKUP && $urandom_range(99) < 85)
          key = key_pool[$urandom_range(pool_n - 1)];
        else
          key = $urandom;
        send_request(op, key);
        if (op != OP_RSVD) sent++;
      end
      settle();
    end

    // Drain with a stall-free receiver so the tail completes quickly.
    recv_stall_pct = 0;
    settle();

    if (err_cnt == 0) begin
      $display("aging_lru_tag_store_tb OK");
    end else begin
      $display("aging_lru_tag_store_tb NOT OK");
    end
    $finish;
  end

endmodule
